// ===== rtl/qssd_pkg.sv =====
// Shared types, constants and codes for the query string split/decode block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qssd_pkg;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Defaults for the top-level parameters
    localparam int MAX_PAIRS_DEF  = 64;
    localparam int FIFO_DEPTH_DEF = 4;

    // Reset value of the pair limit register
    localparam logic [CFG_W-1:0] MAX_PAIRS_RST = 7'd64;

    // Register index of the pair limit (decoded from paddr[2])
    localparam logic REG_MAX_PAIRS = 1'b0;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;  // '?'
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;  // ' '

    // Hex digit offsets: digit, upper-case letter, lower-case letter
    localparam logic [BYTE_W-1:0] HEX_OFS_DIGIT = 8'd48;
    localparam logic [BYTE_W-1:0] HEX_OFS_UPPER = 8'd55;
    localparam logic [BYTE_W-1:0] HEX_OFS_LOWER = 8'd87;

    // Byte class, set by the front end
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_QMARK,
        CLS_HASH,
        CLS_AMP,
        CLS_EQ,
        CLS_PLUS,
        CLS_PCT
    } cls_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_KEY,
        PH_VALUE,
        PH_SKIP,
        PH_DROP
    } phase_t;

    // Percent escape progress
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_HIGH,
        ESC_LOW
    } esc_t;

    // One classified beat in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        cls_t              cls;
        logic              hex_ok;
        logic [3:0]        nibble;
    } beat_t;

endpackage : qssd_pkg

`default_nettype wire

// ===== rtl/query_string_split_decode.sv =====
// Query string split and decode, top level. Depends on qssd_pkg, qssd_front,
// qssd_fifo and qssd_back.
//
// A URL enters one byte per beat on the input channel (in_valid/in_stall),
// in_last on its final byte. Bytes before the first '?' or '#' are dropped;
// the rest is split on '&' into key/value pairs. Each beat gives zero or one
// result on the output channel (out_valid/out_stall): a key byte, a decoded
// value byte, a pair-close marker, or the final result with pair_count.
// The pair limit (max_pairs) is written over the APB port at address 0;
// the user must write it only while the block is idle; nothing enforces it.
// An accepted beat waits in the queue, then its result in the output register.
// Throughput: one byte per cycle while the output is not stalled.
// The classifier writes a FIFO_DEPTH-entry queue; in_stall rises only when
// that queue is full, so a stalled output keeps taking input until then.
// A stalled result holds in the output register. Reset clears the parser,
// the queue and the output valid, and sets max_pairs to 64.
`timescale 1ns / 1ps
`default_nettype none

module query_string_split_decode
    import qssd_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    // Input bytes
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BYTE_W-1:0]  in_byte,
    input  wire logic               in_last,
    // Results
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    has_byte,
    output logic                    in_value,
    output logic [IDX_W-1:0]        pair_index,
    output logic                    pair_end,
    output logic                    query_end,
    output logic [COUNT_W-1:0]      pair_count
);

    logic [CFG_W-1:0] max_pairs_reg;
    logic [CFG_W-1:0] max_pairs_next;
    logic             cfg_wr;
    logic             fifo_full;
    logic             head_valid;
    logic             pop;
    beat_t            front_beat;
    beat_t            head_beat;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAIRS);

    always_comb
    begin
        max_pairs_next = max_pairs_reg;
        if (cfg_wr)
        begin
            max_pairs_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pairs_reg <= MAX_PAIRS_RST;
        end
        else
        begin
            max_pairs_reg <= max_pairs_next;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_PAIRS)
                  ? {{(APB_DW-CFG_W){1'b0}}, max_pairs_reg} : '0;

    // Classifier
    qssd_front u_front (
        .in_byte (in_byte),
        .in_last (in_last),
        .beat    (front_beat)
    );

    // Queue between classifier and parser
    qssd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_beat  (front_beat),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_beat  (head_beat)
    );

    assign in_stall = fifo_full;

    // Parser and output register
    qssd_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_pairs  (max_pairs_reg),
        .head_valid (head_valid),
        .head_beat  (head_beat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .in_value   (in_value),
        .pair_index (pair_index),
        .pair_end   (pair_end),
        .query_end  (query_end),
        .pair_count (pair_count)
    );

endmodule : query_string_split_decode

`default_nettype wire

// ===== rtl/qssd_front.sv =====
// Front end: classifies each incoming byte (delimiters, hex digits).
// Depends on qssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qssd_front
    import qssd_pkg::*;
(
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    output beat_t                  beat
);

    logic [BYTE_W-1:0] sub_digit;
    logic [BYTE_W-1:0] sub_upper;
    logic [BYTE_W-1:0] sub_lower;
    logic              is_digit;
    logic              is_upper;
    logic              is_lower;

    // Hex digit detect and value
    assign sub_digit = in_byte - HEX_OFS_DIGIT;
    assign sub_upper = in_byte - HEX_OFS_UPPER;
    assign sub_lower = in_byte - HEX_OFS_LOWER;
    assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_upper  = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    assign is_lower  = (in_byte >= 8'h61) && (in_byte <= 8'h66);

    // Build the classified beat
    always_comb
    begin
        beat.data   = in_byte;
        beat.last   = in_last;
        beat.hex_ok = is_digit || is_upper || is_lower;
        if (is_digit)
        begin
            beat.nibble = sub_digit[3:0];
        end
        else if (is_upper)
        begin
            beat.nibble = sub_upper[3:0];
        end
        else if (is_lower)
        begin
            beat.nibble = sub_lower[3:0];
        end
        else
        begin
            beat.nibble = 4'd0;
        end

        case (in_byte)
            CH_QMARK: beat.cls = CLS_QMARK;
            CH_HASH:  beat.cls = CLS_HASH;
            CH_AMP:   beat.cls = CLS_AMP;
            CH_EQ:    beat.cls = CLS_EQ;
            CH_PLUS:  beat.cls = CLS_PLUS;
            CH_PCT:   beat.cls = CLS_PCT;
            default:  beat.cls = CLS_OTHER;
        endcase
    end

endmodule : qssd_front

`default_nettype wire

// ===== rtl/qssd_fifo.sv =====
// Short queue of classified beats between the front end and the back end.
// Depends on qssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qssd_fifo
    import qssd_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire beat_t push_beat,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output beat_t      head_beat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    beat_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_beat  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule : qssd_fifo

`default_nettype wire

// ===== rtl/qssd_back.sv =====
// Back end: parser state machine, percent decode, pair counting, output register.
// Depends on qssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qssd_back
    import qssd_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CFG_W-1:0]   max_pairs,
    input  wire logic               head_valid,
    input  wire beat_t              head_beat,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    has_byte,
    output logic                    in_value,
    output logic [IDX_W-1:0]        pair_index,
    output logic                    pair_end,
    output logic                    query_end,
    output logic [COUNT_W-1:0]      pair_count
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam logic [CMP_W-1:0] LIM_MAX = CMP_W'(MAX_PAIRS);

    phase_t           phase_reg, phase_next, phase_upd;
    esc_t             esc_reg, esc_next, esc_upd;
    logic [3:0]       nib_reg, nib_next, nib_upd;
    logic [CNT_W-1:0] pair_reg, pair_next, pair_upd;

    logic [CMP_W-1:0] lim_ext;
    logic [CMP_W-1:0] pair_inc_ext;
    logic [CMP_W-1:0] pair_upd_inc;
    logic             in_pair_now;

    // Result of the current beat
    logic               res_emit;
    logic [BYTE_W-1:0]  res_byte;
    logic               res_has;
    logic               res_val;
    logic               res_pend;
    logic               res_qend;
    logic [COUNT_W-1:0] res_count;
    logic               res_valid;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               has_reg;
    logic               val_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               pend_reg;
    logic               qend_reg;
    logic [COUNT_W-1:0] count_reg;

    // Effective pair limit: zero counts as one, clipped at MAX_PAIRS
    always_comb
    begin
        lim_ext = CMP_W'(max_pairs);
        if (max_pairs == '0)
        begin
            lim_ext = CMP_W'(1);
        end
        else if (lim_ext > LIM_MAX)
        begin
            lim_ext = LIM_MAX;
        end
    end

    assign pair_inc_ext = CMP_W'(pair_reg) + 1'b1;
    assign in_pair_now  = phase_reg inside {PH_KEY, PH_VALUE, PH_SKIP};

    // Next state
    always_comb
    begin
        phase_upd = phase_reg;
        esc_upd   = esc_reg;
        nib_upd   = nib_reg;
        pair_upd  = pair_reg;
        case (phase_reg)
            PH_PREFIX:
            begin
                if (head_beat.cls inside {CLS_QMARK, CLS_HASH})
                begin
                    phase_upd = PH_KEY;
                    esc_upd   = ESC_NONE;
                    pair_upd  = '0;
                end
            end
            PH_KEY, PH_VALUE, PH_SKIP:
            begin
                if (head_beat.cls == CLS_AMP)
                begin
                    esc_upd = ESC_NONE;
                    if (pair_inc_ext < lim_ext)
                    begin
                        pair_upd  = pair_inc_ext[CNT_W-1:0];
                        phase_upd = PH_KEY;
                    end
                    else
                    begin
                        phase_upd = PH_DROP;
                    end
                end
                else if (phase_reg == PH_KEY)
                begin
                    if (head_beat.cls == CLS_EQ)
                    begin
                        phase_upd = PH_VALUE;
                        esc_upd   = ESC_NONE;
                    end
                    else if (head_beat.cls == CLS_HASH)
                    begin
                        phase_upd = PH_SKIP;
                    end
                end
                else if (phase_reg == PH_VALUE)
                begin
                    case (esc_reg)
                        ESC_HIGH:
                        begin
                            if (head_beat.hex_ok)
                            begin
                                nib_upd = head_beat.nibble;
                                esc_upd = ESC_LOW;
                            end
                            else
                            begin
                                phase_upd = PH_SKIP;
                                esc_upd   = ESC_NONE;
                            end
                        end
                        ESC_LOW:
                        begin
                            if (!head_beat.hex_ok)
                            begin
                                phase_upd = PH_SKIP;
                            end
                            esc_upd = ESC_NONE;
                        end
                        default:
                        begin
                            if (head_beat.cls inside {CLS_EQ, CLS_HASH})
                            begin
                                phase_upd = PH_SKIP;
                                esc_upd   = ESC_NONE;
                            end
                            else if (head_beat.cls == CLS_PCT)
                            begin
                                esc_upd = ESC_HIGH;
                            end
                            else
                            begin
                                esc_upd = ESC_NONE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // drop phase holds until the final byte
            end
        endcase

        // Final byte returns everything to reset values
        if (head_beat.last)
        begin
            phase_next = PH_PREFIX;
            esc_next   = ESC_NONE;
            nib_next   = 4'd0;
            pair_next  = '0;
        end
        else
        begin
            phase_next = phase_upd;
            esc_next   = esc_upd;
            nib_next   = nib_upd;
            pair_next  = pair_upd;
        end
    end

    assign pair_upd_inc = CMP_W'(pair_upd) + 1'b1;

    // Result of this beat
    always_comb
    begin
        res_emit  = 1'b0;
        res_byte  = '0;
        res_has   = 1'b0;
        res_val   = 1'b0;
        res_pend  = 1'b0;
        res_qend  = 1'b0;
        res_count = '0;
        if (in_pair_now)
        begin
            if (head_beat.cls == CLS_AMP)
            begin
                res_pend = 1'b1;
                res_emit = 1'b1;
            end
            else if (phase_reg == PH_KEY)
            begin
                if (!(head_beat.cls inside {CLS_EQ, CLS_HASH}))
                begin
                    res_byte = head_beat.data;
                    res_has  = 1'b1;
                    res_emit = 1'b1;
                end
            end
            else if (phase_reg == PH_VALUE)
            begin
                case (esc_reg)
                    ESC_HIGH:
                    begin
                        // first hex digit only stored
                    end
                    ESC_LOW:
                    begin
                        if (head_beat.hex_ok)
                        begin
                            res_byte = {nib_reg, head_beat.nibble};
                            res_has  = 1'b1;
                            res_val  = 1'b1;
                            res_emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (head_beat.cls == CLS_PLUS)
                        begin
                            res_byte = CH_SPACE;
                            res_has  = 1'b1;
                            res_val  = 1'b1;
                            res_emit = 1'b1;
                        end
                        else if (!(head_beat.cls inside {CLS_EQ, CLS_HASH, CLS_PCT}))
                        begin
                            res_byte = head_beat.data;
                            res_has  = 1'b1;
                            res_val  = 1'b1;
                            res_emit = 1'b1;
                        end
                    end
                endcase
            end
        end

        // Final byte closes any open pair and reports the count
        if (head_beat.last)
        begin
            res_qend = 1'b1;
            if (phase_upd inside {PH_KEY, PH_VALUE, PH_SKIP})
            begin
                res_pend = 1'b1;
            end
            if (phase_upd != PH_PREFIX)
            begin
                res_count = pair_upd_inc[COUNT_W-1:0];
            end
        end
        res_valid = res_emit || head_beat.last;
    end

    // Take a beat whenever the output slot is free or draining
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            esc_reg       <= ESC_NONE;
            nib_reg       <= 4'd0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                nib_reg   <= nib_next;
                pair_reg  <= pair_next;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            byte_reg  <= res_byte;
            has_reg   <= res_has;
            val_reg   <= res_val;
            idx_reg   <= pair_inc_ext[IDX_W-1:0] - 1'b1;
            pend_reg  <= res_pend;
            qend_reg  <= res_qend;
            count_reg <= res_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign has_byte   = has_reg;
    assign in_value   = val_reg;
    assign pair_index = idx_reg;
    assign pair_end   = pend_reg;
    assign query_end  = qend_reg;
    assign pair_count = count_reg;

endmodule : qssd_back

`default_nettype wire

// ===== rtl/qssd_checker.sv =====
// Port-level checks for query_string_split_decode, bound to the top level.
// Depends on qssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qssd_checker
    import qssd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [BYTE_W-1:0]  out_byte,
    input wire logic               has_byte,
    input wire logic               in_value,
    input wire logic               pair_end,
    input wire logic               query_end,
    input wire logic [COUNT_W-1:0] pair_count
);

    // Stalled result beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(pair_count))
        else $error("result changed while stalled");

    // No data byte means a zero byte and no value flag
    a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_byte == '0 && !in_value)
        else $error("marker result carries data");

    // Count only on the final result
    a_count_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !query_end |-> pair_count == '0)
        else $error("pair count outside final result");

    // A result without data that is not final must close a pair
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte && !query_end |-> pair_end)
        else $error("empty result that closes nothing");

    // Data byte never also closes a pair unless it ends the query
    a_byte_no_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte && !query_end |-> !pair_end)
        else $error("data byte marked as pair close");

endmodule : qssd_checker

bind query_string_split_decode qssd_checker u_qssd_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for query_string_split_decode: URL bytes in, key/value
// results out, checked against a cycle-free model of the parser kept in this file.
// Depends on qssd_pkg and the RTL of query_string_split_decode.
`timescale 1ns / 1ps

module tb;
    import qssd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_BEATS    = 75;
    localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam logic [APB_AW-1:0] ADDR_MAX_PAIRS = {REG_MAX_PAIRS, 2'b00};

    // One result beat, field by field
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               has_data;
        logic               is_value;
        logic [IDX_W-1:0]   pair_idx;
        logic               closes_pair;
        logic               closes_query;
        logic [COUNT_W-1:0] pair_total;
    } res_t;

    // Directed stimulus row; typed rows carry the result to expect
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        res_t              want;
    } row_t;

    localparam int N_ROWS = 27;
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{CH_QMARK, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b1, 7'd1}}, // lone '?'
        '{8'hFF,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b0, 1'b1, 7'd0}}, // no query
        '{"a",      1'b0, 1'b0, '0},
        '{CH_HASH,  1'b0, 1'b0, '0},
        '{8'h00,    1'b0, 1'b0, '0},                                          // zero key byte
        '{8'hFF,    1'b0, 1'b0, '0},
        '{CH_EQ,    1'b0, 1'b0, '0},
        '{CH_PLUS,  1'b0, 1'b0, '0},                                          // '+' -> space
        '{CH_PCT,   1'b0, 1'b0, '0},
        '{"4",      1'b0, 1'b0, '0},
        '{"a",      1'b0, 1'b0, '0},                                          // %4a
        '{CH_EQ,    1'b0, 1'b0, '0},                                          // '=' in value
        '{"x",      1'b0, 1'b0, '0},
        '{CH_AMP,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 7'd0}},
        '{"k",      1'b0, 1'b0, '0},
        '{CH_HASH,  1'b0, 1'b0, '0},                                          // '#' ends key
        '{CH_AMP,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd1, 1'b1, 1'b0, 7'd0}},
        '{CH_EQ,    1'b0, 1'b0, '0},                                          // empty key
        '{CH_PCT,   1'b0, 1'b0, '0},
        '{"F",      1'b0, 1'b0, '0},
        '{"f",      1'b0, 1'b0, '0},                                          // %Ff
        '{CH_PCT,   1'b0, 1'b0, '0},
        '{"g",      1'b0, 1'b0, '0},                                          // bad escape
        '{CH_AMP,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd2, 1'b1, 1'b0, 7'd0}},
        '{CH_EQ,    1'b0, 1'b0, '0},
        '{CH_PCT,   1'b0, 1'b0, '0},
        '{CH_AMP,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd3, 1'b1, 1'b1, 7'd5}}  // '&' ends URL
    };

    // Clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [BYTE_W-1:0] in_byte = '0;
    logic in_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic has_byte;
    logic in_value;
    logic [IDX_W-1:0] pair_index;
    logic pair_end;
    logic query_end;
    logic [COUNT_W-1:0] pair_count;

    // Typed expectation travels with its beat
    logic row_typed = 1'b0;
    res_t row_want = '0;

    // Parser model state
    phase_t parse_phase = PH_PREFIX;
    esc_t escape_state = ESC_NONE;
    logic [3:0] high_nib = '0;
    logic [6:0] pair_ctr = '0;
    logic [CFG_W-1:0] limit_reg = MAX_PAIRS_RST;

    res_t pending_results[$];
    logic [BYTE_W-1:0] url_bytes[$];
    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int phase_beats = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    always #2 clk = ~clk;

    query_string_split_decode u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .in_value   (in_value),
        .pair_index (pair_index),
        .pair_end   (pair_end),
        .query_end  (query_end),
        .pair_count (pair_count)
    );

    function automatic bit is_hex(input logic [BYTE_W-1:0] c);
        return c inside {["0":"9"], ["A":"F"], ["a":"f"]};
    endfunction

    function automatic logic [3:0] hex_nib(input logic [BYTE_W-1:0] c);
        if (c inside {["0":"9"]})
            return 4'(c - HEX_OFS_DIGIT);
        if (c inside {["A":"F"]})
            return 4'(c - HEX_OFS_UPPER);
        if (c inside {["a":"f"]})
            return 4'(c - HEX_OFS_LOWER);
        return 4'h0;
    endfunction

    // Parser model: advance on one byte, return 1 when the byte yields a result
    function automatic bit split_decode_step(input logic [BYTE_W-1:0] c, input logic last,
                                             output res_t r);
        int lim;
        logic [BYTE_W-1:0] obyte;
        logic [IDX_W-1:0] idx;
        bit has, val, pend, emit;
        lim = (limit_reg == 0) ? 1 : ((int'(limit_reg) > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF
                                                                         : int'(limit_reg));
        obyte = '0;
        idx = pair_ctr[IDX_W-1:0];
        has = 0;
        val = 0;
        pend = 0;
        emit = 0;
        r = '0;
        case (parse_phase)
            PH_PREFIX:
            begin
                if (c == CH_QMARK || c == CH_HASH)
                begin
                    parse_phase = PH_KEY;
                    escape_state = ESC_NONE;
                    pair_ctr = '0;
                    idx = '0;
                end
            end
            PH_KEY, PH_VALUE, PH_SKIP:
            begin
                if (c == CH_AMP)
                begin
                    // '&' closes the pair, even mid escape
                    pend = 1;
                    emit = 1;
                    escape_state = ESC_NONE;
                    if (int'(pair_ctr) + 1 < lim)
                    begin
                        pair_ctr = pair_ctr + 7'd1;
                        parse_phase = PH_KEY;
                    end
                    else
                    begin
                        parse_phase = PH_DROP;
                    end
                end
                else if (parse_phase == PH_KEY)
                begin
                    if (c == CH_EQ)
                    begin
                        parse_phase = PH_VALUE;
                        escape_state = ESC_NONE;
                    end
                    else if (c == CH_HASH)
                    begin
                        parse_phase = PH_SKIP;
                    end
                    else
                    begin
                        obyte = c;
                        has = 1;
                        emit = 1;
                    end
                end
                else if (parse_phase == PH_VALUE)
                begin
                    if (escape_state == ESC_HIGH)
                    begin
                        if (is_hex(c))
                        begin
                            high_nib = hex_nib(c);
                            escape_state = ESC_LOW;
                        end
                        else
                        begin
                            parse_phase = PH_SKIP;
                            escape_state = ESC_NONE;
                        end
                    end
                    else if (escape_state == ESC_LOW)
                    begin
                        if (is_hex(c))
                        begin
                            obyte = {high_nib, hex_nib(c)};
                            has = 1;
                            val = 1;
                            emit = 1;
                        end
                        else
                        begin
                            parse_phase = PH_SKIP;
                        end
                        escape_state = ESC_NONE;
                    end
                    else if (c == CH_EQ || c == CH_HASH)
                    begin
                        parse_phase = PH_SKIP;
                        escape_state = ESC_NONE;
                    end
                    else if (c == CH_PLUS)
                    begin
                        obyte = CH_SPACE;
                        has = 1;
                        val = 1;
                        emit = 1;
                    end
                    else if (c == CH_PCT)
                    begin
                        escape_state = ESC_HIGH;
                    end
                    else
                    begin
                        obyte = c;
                        has = 1;
                        val = 1;
                        emit = 1;
                    end
                end
            end
            default: ;
        endcase
        if (!last && !emit)
            return 0;
        r.data = obyte;
        r.has_data = has;
        r.is_value = val;
        r.pair_idx = idx;
        if (last)
        begin
            // final byte closes any open pair and reports the count
            if (parse_phase inside {PH_KEY, PH_VALUE, PH_SKIP})
                pend = 1;
            r.closes_query = 1'b1;
            r.pair_total = (parse_phase == PH_PREFIX) ? '0 : 7'(pair_ctr + 7'd1);
            parse_phase = PH_PREFIX;
            escape_state = ESC_NONE;
            high_nib = '0;
            pair_ctr = '0;
        end
        r.closes_pair = pend;
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    endtask

    // Predict on accepted input beats, check accepted result beats, watchdog
    always @(posedge clk)
    begin
        res_t exp_res;
        res_t got;
        bit any_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                any_res = split_decode_step(in_byte, in_last, exp_res);
                if (row_typed)
                    pending_results = {pending_results, row_want};
                else if (any_res)
                    pending_results = {pending_results, exp_res};
            end
            if (out_valid && !out_stall)
            begin
                got = '{out_byte, has_byte, in_value, pair_index, pair_end, query_end,
                        pair_count};
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, out_byte", got.data, 0);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (got.data !== exp_res.data)
                        report_mismatch("out_byte", got.data, exp_res.data);
                    if (got.has_data !== exp_res.has_data)
                        report_mismatch("has_byte", got.has_data, exp_res.has_data);
                    if (got.is_value !== exp_res.is_value)
                        report_mismatch("in_value", got.is_value, exp_res.is_value);
                    if (got.pair_idx !== exp_res.pair_idx)
                        report_mismatch("pair_index", got.pair_idx, exp_res.pair_idx);
                    if (got.closes_pair !== exp_res.closes_pair)
                        report_mismatch("pair_end", got.closes_pair, exp_res.closes_pair);
                    if (got.closes_query !== exp_res.closes_query)
                        report_mismatch("query_end", got.closes_query, exp_res.closes_query);
                    if (got.pair_total !== exp_res.pair_total)
                        report_mismatch("pair_count", got.pair_total, exp_res.pair_total);
                end
                results_seen++;
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Drive one beat, with an optional gap in front, and wait for it to be taken
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last,
                             input logic typed, input res_t want);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        phase_beats++;
    endtask

    task automatic send_url();
        for (int i = 0; i < url_bytes.size(); i++)
            send_beat(url_bytes[i], i == url_bytes.size() - 1, 1'b0, '0);
    endtask

    // Hold input off until all results are out and the queue has drained
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_pairs(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_PAIRS;
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_reg = CFG_W'(value);
    endtask

    // Append one byte to the URL under construction
    task automatic append_byte(input logic [BYTE_W-1:0] b);
        url_bytes = {url_bytes, b};
    endtask

    // Any byte that is not one of the parser's delimiters
    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 3) != 0)
            return ALNUM[$urandom_range(0, ALNUM.len() - 1)];
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b inside {CH_QMARK, CH_HASH, CH_AMP, CH_EQ, CH_PLUS, CH_PCT});
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] key_byte();
        case ($urandom_range(0, 9))
            0: return CH_PLUS;
            1: return CH_PCT;
            2: return CH_QMARK;
            default: return text_byte();
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return BYTE_W'(v) + HEX_OFS_DIGIT;
        return BYTE_W'(v) + ($urandom_range(0, 1) ? HEX_OFS_UPPER : HEX_OFS_LOWER);
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_char();
        logic [BYTE_W-1:0] b;
        do
            b = text_byte();
        while (is_hex(b));
        return b;
    endfunction

    // One value token: plain, '+', escapes good and bad, early terminators
    task automatic push_value_token();
        case ($urandom_range(0, 9))
            0, 1, 2: append_byte(text_byte());
            3: append_byte(CH_PLUS);
            4, 5:
            begin
                append_byte(CH_PCT);
                append_byte(hex_char());
                append_byte(hex_char());
            end
            6:
            begin
                append_byte(CH_PCT);
                if ($urandom_range(0, 1))
                    append_byte(hex_char());
                append_byte(non_hex_char());
            end
            7:
            begin
                append_byte($urandom_range(0, 1) ? CH_EQ : CH_HASH);
                append_byte(text_byte());
            end
            8: append_byte(CH_PCT);
            default: append_byte(CH_QMARK);
        endcase
    endtask

    task automatic push_pair();
        int kind;
        repeat ($urandom_range(0, 3)) append_byte(key_byte());
        kind = $urandom_range(0, 7);
        if (kind == 1)
        begin
            append_byte(CH_HASH);
            repeat ($urandom_range(0, 2)) append_byte(text_byte());
        end
        else if (kind != 0)
        begin
            append_byte(CH_EQ);
            repeat ($urandom_range(0, 4)) push_value_token();
        end
    endtask

    // Mostly well-formed URLs with random content; some raw noise
    task automatic send_random_url(input int lim);
        int npairs;
        url_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) append_byte(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3)) append_byte(text_byte());
            if ($urandom_range(0, 11) != 0)
                append_byte($urandom_range(0, 3) == 0 ? CH_HASH : CH_QMARK);
            npairs = $urandom_range(1, (lim < 6) ? lim + 2 : 5);
            for (int p = 0; p < npairs; p++)
            begin
                if (p != 0)
                    append_byte(CH_AMP);
                push_pair();
            end
            if ($urandom_range(0, 7) == 0)
                append_byte(CH_AMP);
        end
        if (url_bytes.size() == 0)
            append_byte(text_byte());
        send_url();
    endtask

    // Runs past the full pair limit, so pair index reaches its top value
    task automatic send_long_url();
        url_bytes.delete();
        append_byte(CH_QMARK);
        repeat (MAX_PAIRS_DEF + 2)
        begin
            append_byte(text_byte());
            append_byte(CH_AMP);
        end
        append_byte(text_byte());
        send_url();
    endtask

    // Stimulus: reset, directed table, then random phases at several limits
    initial
    begin
        int limit_plan [7];
        limit_plan = '{1, 2, 64, 5, 3, 0, 64};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_drained();
            if (limit_plan[ph] == 0)
                limit_plan[ph] = $urandom_range(1, 64);
            // no idling at all in the closing phase
            if (ph == 6)
                idle_on = 1'b0;
            write_max_pairs(limit_plan[ph]);
            phase_beats = 0;
            if (ph == 2)
                send_long_url();
            while (phase_beats < PHASE_BEATS)
                send_random_url(limit_plan[ph]);
        end

        wait_drained();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
